/* sv/hrbp_pkg.sv */
// hrbp_pkg: shared types and constants for the http request byte parser
// used by hrbp_step and http_request_byte_parser; no dependencies
package hrbp_pkg;

   // parser phases
   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_ROUTE   = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_LINE    = 3'd3;
   localparam logic [2:0] PH_HEADER  = 3'd4;
   localparam logic [2:0] PH_BODY    = 3'd5;

   // part tags
   localparam logic [2:0] PART_METHOD  = 3'd0;
   localparam logic [2:0] PART_ROUTE   = 3'd1;
   localparam logic [2:0] PART_VERSION = 3'd2;
   localparam logic [2:0] PART_HEADER  = 3'd3;
   localparam logic [2:0] PART_LINEEND = 3'd4;
   localparam logic [2:0] PART_BLANK   = 3'd5;
   localparam logic [2:0] PART_BODY    = 3'd6;

   // method codes
   localparam logic [2:0] METH_NONE   = 3'd0;
   localparam logic [2:0] METH_GET    = 3'd1;
   localparam logic [2:0] METH_POST   = 3'd2;
   localparam logic [2:0] METH_PUT    = 3'd3;
   localparam logic [2:0] METH_PATCH  = 3'd4;
   localparam logic [2:0] METH_DELETE = 3'd5;

   // method field lengths, word plus space
   localparam logic [2:0] LEN_GET    = 3'd4;
   localparam logic [2:0] LEN_POST   = 3'd5;
   localparam logic [2:0] LEN_PUT    = 3'd4;
   localparam logic [2:0] LEN_PATCH  = 3'd6;
   localparam logic [2:0] LEN_DELETE = 3'd7;

   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_U     = 8'h55;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [3:0] VERSION_CHECKED = 4'd9;
   localparam logic [3:0] VERSION_LEN     = 4'd10;

   typedef struct packed {
      logic [2:0] phase;
      logic [3:0] field_position;
      logic [2:0] method_seen;
      logic [2:0] method_length;
      logic [7:0] header_total;
      logic       error_flag;
      logic       cr_seen;
   } state_type;

   typedef struct packed {
      logic [2:0] part;
      logic       field_start;
      logic       field_end;
      logic [2:0] method_code;
      logic [7:0] header_number;
      logic       parse_error;
      logic       request_done;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_METHOD, field_position: 4'd0, method_seen: METH_NONE,
      method_length: 3'd0, header_total: 8'd0, error_flag: 1'b0, cr_seen: 1'b0
   };

   // expected version text "HTTP/1.1\r"
   function automatic logic [7:0] version_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h48;
         4'd1:    c = 8'h54;
         4'd2:    c = 8'h54;
         4'd3:    c = 8'h50;
         4'd4:    c = 8'h2F;
         4'd5:    c = 8'h31;
         4'd6:    c = 8'h2E;
         4'd7:    c = 8'h31;
         4'd8:    c = CH_CR;
         default: c = CH_LF;
      endcase
      return c;
   endfunction

endpackage

/* sv/hrbp_step.sv */
// hrbp_step: next parser state and byte tag for one incoming byte
// combinational; depends on hrbp_pkg
module hrbp_step (
   input  hrbp_pkg::state_type  state_cur,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output hrbp_pkg::state_type  state_nxt,
   output hrbp_pkg::result_type result
);
   import hrbp_pkg::*;

   function automatic state_type fail_state(input state_type s);
      state_type f;
      f = s;
      f.error_flag     = 1'b1;
      f.phase          = PH_BODY;
      f.field_position = 4'd1;
      f.cr_seen        = 1'b0;
      return f;
   endfunction

   state_type  s;
   logic [2:0] part;
   logic       fs;
   logic       fe;
   logic       trunc;

   always_comb begin
      s    = state_cur;
      part = PART_BODY;
      fs   = 1'b0;
      fe   = 1'b0;
      unique case (state_cur.phase)
         PH_METHOD: begin
            part = PART_METHOD;
            if (s.field_position == 4'd0) begin
               if (data_byte == CH_D) begin
                  s.method_seen = METH_DELETE; s.method_length = LEN_DELETE;
               end else if (data_byte == CH_G) begin
                  s.method_seen = METH_GET; s.method_length = LEN_GET;
               end
            end else if (s.field_position == 4'd1 && s.method_seen == METH_NONE) begin
               if (data_byte == CH_O) begin
                  s.method_seen = METH_POST; s.method_length = LEN_POST;
               end else if (data_byte == CH_U) begin
                  s.method_seen = METH_PUT; s.method_length = LEN_PUT;
               end else if (data_byte == CH_A) begin
                  s.method_seen = METH_PATCH; s.method_length = LEN_PATCH;
               end
            end
            if (s.field_position != 4'd0 && s.method_seen == METH_NONE) begin
               s = fail_state(s);
            end else begin
               s.field_position = s.field_position + 4'd1;
               if (s.method_seen != METH_NONE &&
                   s.field_position >= {1'b0, s.method_length}) begin
                  s.phase          = PH_ROUTE;
                  s.field_position = 4'd0;
               end
            end
         end
         PH_ROUTE: begin
            part = PART_ROUTE;
            fs   = (s.field_position == 4'd0);
            s.field_position = 4'd1;
            if (data_byte == CH_SPACE) begin
               fe               = 1'b1;
               s.phase          = PH_VERSION;
               s.field_position = 4'd0;
            end
         end
         PH_VERSION: begin
            part = PART_VERSION;
            if (s.field_position < VERSION_CHECKED &&
                data_byte != version_char(s.field_position)) begin
               s = fail_state(s);
            end else begin
               s.field_position = s.field_position + 4'd1;
               if (s.field_position >= VERSION_LEN) begin
                  s.phase          = PH_LINE;
                  s.field_position = 4'd0;
               end
            end
         end
         PH_LINE: begin
            if (s.cr_seen) begin
               part = PART_BLANK;
               if (data_byte != CH_LF) begin
                  s = fail_state(s);
               end else begin
                  s.cr_seen        = 1'b0;
                  s.phase          = PH_BODY;
                  s.field_position = 4'd0;
               end
            end else if (data_byte == CH_CR) begin
               part      = PART_BLANK;
               s.cr_seen = 1'b1;
            end else if (data_byte == CH_LF) begin
               part = PART_LINEEND;
               s    = fail_state(s);
            end else begin
               part    = PART_HEADER;
               fs      = 1'b1;
               s.phase = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (s.cr_seen) begin
               part = PART_LINEEND;
               if (data_byte != CH_LF) begin
                  s = fail_state(s);
               end else begin
                  s.cr_seen = 1'b0;
                  if (s.header_total != 8'hFF) s.header_total = s.header_total + 8'd1;
                  s.phase = PH_LINE;
               end
            end else if (data_byte == CH_CR) begin
               part      = PART_LINEEND;
               fe        = 1'b1;
               s.cr_seen = 1'b1;
            end else if (data_byte == CH_LF) begin
               part = PART_LINEEND;
               s    = fail_state(s);
            end else begin
               part = PART_HEADER;
            end
         end
         default: begin
            part = PART_BODY;
            fs   = (s.field_position == 4'd0);
            s.field_position = 4'd1;
            s.phase          = PH_BODY;
         end
      endcase

      // ending before the headers counts as truncation
      trunc = last_byte &&
              (s.phase == PH_METHOD || s.phase == PH_ROUTE || s.phase == PH_VERSION);
      if (trunc) s.error_flag = 1'b1;

      result.part          = part;
      result.field_start   = fs;
      result.field_end     = fe;
      result.method_code   = s.method_seen;
      result.header_number = s.header_total;
      result.parse_error   = s.error_flag;
      result.request_done  = last_byte;

      state_nxt = last_byte ? STATE_RESET : s;
   end

endmodule

/* sv/http_request_byte_parser.sv */
// http_request_byte_parser: tags each byte of an http/1.1 request stream
// the tag is registered: rsp_valid rises in the cycle after the req transaction;
// throughput 1 byte per cycle while rsp_ready stays high
// a byte enters only when the tag register is empty or its tag leaves that cycle
// synchronous active-high reset returns the parser to the method phase, no output
// depends on hrbp_pkg and hrbp_step
module http_request_byte_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_part,
   output logic       rsp_field_start,
   output logic       rsp_field_end,
   output logic [2:0] rsp_method_code,
   output logic [7:0] rsp_header_number,
   output logic       rsp_parse_error,
   output logic       rsp_request_done
);
   import hrbp_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_take;

   hrbp_step u_step (
      .state_cur (state_ff),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .state_nxt (state_in),
      .result    (result_in)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_take     = req_valid && req_ready;
   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) result_ff <= result_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_part          = result_ff.part;
   assign rsp_field_start   = result_ff.field_start;
   assign rsp_field_end     = result_ff.field_end;
   assign rsp_method_code   = result_ff.method_code;
   assign rsp_header_number = result_ff.header_number;
   assign rsp_parse_error   = result_ff.parse_error;
   assign rsp_request_done  = result_ff.request_done;

endmodule
